@@ hdl/llzc_pkg.sv @@
// Shared types and constants for the laser line zero crossing block.
`default_nettype none

package llzc_pkg;

   // Field widths of the pixel and result transactions.
   localparam int unsigned SAMPLE_W   = 8;
   localparam int unsigned MID_W      = 9;
   localparam int unsigned COL_W      = 12;
   localparam int unsigned ROW_W      = 12;
   localparam int unsigned IMAGE_W    = 8;
   localparam int unsigned POS_W      = 20;
   localparam int unsigned RIGHT_W    = 13;
   localparam int unsigned DIFF_W     = 11;
   localparam int unsigned NUM_W      = 9;
   localparam int unsigned DEN_W      = 10;

   // Columns at or beyond this limit never close a pair.
   localparam int unsigned MAX_COLUMNS = 4096;

   // Default number of fraction bits in the subpixel column.
   localparam int unsigned FRACTION_BITS_DEF = 8;

   // Depth of the row job queue between the front and back parts.
   localparam int unsigned JOB_DEPTH = 2;

   // Configuration port.
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 13;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT_COLUMN  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT_COLUMN = 1'b1;
   localparam logic [RIGHT_W-1:0]     RIGHT_RESET      = 13'd4096;

   // One finished row handed from the front part to the back part.
   typedef struct packed {
      logic [IMAGE_W-1:0] image;
      logic [ROW_W-1:0]   row;
      logic               found;
      logic [COL_W-1:0]   x;
      logic [NUM_W-1:0]   num;
      logic [DEN_W-1:0]   den;
   } job_type;

   localparam int unsigned JOB_W = $bits(job_type);

endpackage : llzc_pkg

`default_nettype wire

@@ hdl/laser_line_zero_crossing.sv @@
// Top level of the laser line zero crossing finder.
//
//   Channel   Direction  Handshake        Content
//   req_      in         push / full      one pixel of a row
//   rsp_      out        pop / empty      one result per finished row
//   csr_      in         we               left_column, right_column
//
// Pixels are taken at one per cycle while the job queue has room; the front
// part never waits on a pixel. For each row the back part loads the job,
// derives one quotient bit per cycle and hands the result off; rows that
// arrive faster than the back part drains them fill the job queue and raise
// req_full. The result register frees the divider while a result waits.
// Reset is synchronous; it clears the row state and sets the region to all columns.
`default_nettype none

module laser_line_zero_crossing
   import llzc_pkg::*;
#(
   parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   output logic                        req_full,
   input  wire logic [SAMPLE_W-1:0]    req_red_sample,
   input  wire logic [MID_W-1:0]       req_midpoint_doubled,
   input  wire logic [COL_W-1:0]       req_column,
   input  wire logic [ROW_W-1:0]       req_row,
   input  wire logic [IMAGE_W-1:0]     req_image_index,
   input  wire logic                   req_last_in_row,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output logic [IMAGE_W-1:0]          rsp_out_image,
   output logic [ROW_W-1:0]            rsp_out_row,
   output logic                        rsp_crossing_found,
   output logic [POS_W-1:0]            rsp_crossing_column,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   job_type push_job, head_job;
   logic    job_push, job_pop, job_empty, queue_full, accept;

   // A pixel transaction is taken whenever the job queue has room.
   assign req_full = queue_full;
   assign accept   = req_push && !queue_full;

   llzc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .accept           (accept),
      .red_sample       (req_red_sample),
      .midpoint_doubled (req_midpoint_doubled),
      .column           (req_column),
      .row              (req_row),
      .image_index      (req_image_index),
      .last_in_row      (req_last_in_row),
      .job              (push_job),
      .job_push         (job_push)
   );

   llzc_job_queue #(
      .DEPTH (JOB_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (job_pop),
      .head_job (head_job),
      .empty    (job_empty)
   );

   llzc_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .job                 (head_job),
      .job_empty           (job_empty),
      .job_pop             (job_pop),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_out_image       (rsp_out_image),
      .rsp_out_row         (rsp_out_row),
      .rsp_crossing_found  (rsp_crossing_found),
      .rsp_crossing_column (rsp_crossing_column)
   );

endmodule : laser_line_zero_crossing

`default_nettype wire

@@ hdl/llzc_front.sv @@
// Front part: configuration registers, pair classification and row jobs.
`default_nettype none

module llzc_front
   import llzc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   accept,
   input  wire logic [SAMPLE_W-1:0]    red_sample,
   input  wire logic [MID_W-1:0]       midpoint_doubled,
   input  wire logic [COL_W-1:0]       column,
   input  wire logic [ROW_W-1:0]       row,
   input  wire logic [IMAGE_W-1:0]     image_index,
   input  wire logic                   last_in_row,
   output job_type                     job,
   output logic                        job_push
);

   logic [COL_W-1:0]    left_ff, left_in;
   logic [RIGHT_W-1:0]  right_ff, right_in;
   logic [SAMPLE_W-1:0] prev_ff, prev_in;
   logic                prev_valid_ff, prev_valid_in;
   logic                found_ff, found_in;
   logic [COL_W-1:0]    x_ff, x_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [DEN_W-1:0]    den_ff, den_in;

   logic [DIFF_W-1:0]   prev2, red2, mid2, d0, d1, neg_d0, span;
   logic [COL_W-1:0]    pair_x;
   logic                col_ok, crossing, take;

   // Doubled differences against the midpoint of the later sample.
   always_comb begin
      prev2  = {2'b00, prev_ff, 1'b0};
      red2   = {2'b00, red_sample, 1'b0};
      mid2   = {2'b00, midpoint_doubled};
      d0     = prev2 - mid2;
      d1     = red2 - mid2;
      neg_d0 = mid2 - prev2;
      span   = red2 - prev2;
   end

   // The pair (x, x+1) must lie inside the object region.
   always_comb begin
      pair_x   = column - COL_W'(1);
      col_ok   = (column != '0) && (pair_x >= left_ff) &&
                 ({1'b0, column} < right_ff) &&
                 (32'(column) < 32'(MAX_COLUMNS));
      crossing = d0[DIFF_W-1] && !d1[DIFF_W-1] && (d1 != '0);
      take     = accept && prev_valid_ff && !found_ff && col_ok && crossing;
   end

   // Row state update; a row ends with its last sample.
   always_comb begin
      left_in       = left_ff;
      right_in      = right_ff;
      prev_in       = prev_ff;
      prev_valid_in = prev_valid_ff;
      found_in      = found_ff;
      x_in          = x_ff;
      num_in        = num_ff;
      den_in        = den_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_LEFT_COLUMN:  left_in  = csr_wdata[COL_W-1:0];
            CSR_RIGHT_COLUMN: right_in = csr_wdata[RIGHT_W-1:0];
            default: ;
         endcase
      end

      if (take) begin
         found_in = 1'b1;
         x_in     = pair_x;
         num_in   = neg_d0[NUM_W-1:0];
         den_in   = span[DEN_W-1:0];
      end

      job.image = image_index;
      job.row   = row;
      job.found = found_in;
      job.x     = x_in;
      job.num   = num_in;
      job.den   = den_in;
      job_push  = accept && last_in_row;

      if (accept) begin
         prev_in       = red_sample;
         prev_valid_in = 1'b1;
         if (last_in_row) begin
            prev_in       = '0;
            prev_valid_in = 1'b0;
            found_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff       <= '0;
         right_ff      <= RIGHT_RESET;
         prev_ff       <= '0;
         prev_valid_ff <= 1'b0;
         found_ff      <= 1'b0;
      end else begin
         left_ff       <= left_in;
         right_ff      <= right_in;
         prev_ff       <= prev_in;
         prev_valid_ff <= prev_valid_in;
         found_ff      <= found_in;
      end
      x_ff   <= x_in;
      num_ff <= num_in;
      den_ff <= den_in;
   end

endmodule : llzc_front

`default_nettype wire

@@ hdl/llzc_job_queue.sv @@
// Short queue of row jobs between the front and back parts.
`default_nettype none

module llzc_job_queue
   import llzc_pkg::*;
#(
   parameter int unsigned DEPTH = JOB_DEPTH
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  job_type   push_job,
   output logic      full,
   input  wire logic pop,
   output job_type   head_job,
   output logic      empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   job_type            slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   // Pointer and fill count bookkeeping.
   always_comb begin
      full     = (count_ff == CNT_W'(DEPTH));
      empty    = (count_ff == '0);
      do_push  = push && !full;
      do_pop   = pop && !empty;
      head_job = slots_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule : llzc_job_queue

`default_nettype wire

@@ hdl/llzc_back.sv @@
// Back part: bit-serial fraction divider and the result register.
`default_nettype none

module llzc_back
   import llzc_pkg::*;
#(
   parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  job_type                 job,
   input  wire logic               job_empty,
   output logic                    job_pop,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic [IMAGE_W-1:0]      rsp_out_image,
   output logic [ROW_W-1:0]        rsp_out_row,
   output logic                    rsp_crossing_found,
   output logic [POS_W-1:0]        rsp_crossing_column
);

   localparam int unsigned CNT_W = $clog2(FRACTION_BITS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [DEN_W-1:0]         rem_ff, rem_in;
   logic [FRACTION_BITS-1:0] quot_ff, quot_in;
   job_type                  cur_ff, cur_in;

   logic                     out_valid_ff, out_valid_in;
   logic [IMAGE_W-1:0]       out_image_ff, out_image_in;
   logic [ROW_W-1:0]         out_row_ff, out_row_in;
   logic                     out_found_ff, out_found_in;
   logic [POS_W-1:0]         out_pos_ff, out_pos_in;

   logic [DEN_W:0]           rem2, rem_sub;
   logic                     ge;
   logic [FRACTION_BITS:0]   qshift;
   logic [31:0]              pos_wide;

   // One quotient bit per cycle, restoring division.
   always_comb begin
      rem2     = {rem_ff, 1'b0};
      ge       = rem2 >= {1'b0, cur_ff.den};
      rem_sub  = rem2 - {1'b0, cur_ff.den};
      qshift   = {quot_ff, ge};
      pos_wide = 32'({cur_ff.x, quot_ff});
   end

   // Sequencer and result register.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      cur_in       = cur_ff;
      job_pop      = 1'b0;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_image_in = out_image_ff;
      out_row_in   = out_row_ff;
      out_found_in = out_found_ff;
      out_pos_in   = out_pos_ff;

      case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               cur_in   = job;
               rem_in   = DEN_W'(job.num);
               quot_in  = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = ge ? rem_sub[DEN_W-1:0] : rem2[DEN_W-1:0];
            quot_in = qshift[FRACTION_BITS-1:0];
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(FRACTION_BITS - 1)) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               out_image_in = cur_ff.image;
               out_row_in   = cur_ff.row;
               out_found_in = cur_ff.found;
               out_pos_in   = cur_ff.found ? pos_wide[POS_W-1:0] : '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_empty           = !out_valid_ff;
   assign rsp_out_image       = out_image_ff;
   assign rsp_out_row         = out_row_ff;
   assign rsp_crossing_found  = out_found_ff;
   assign rsp_crossing_column = out_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      cnt_ff       <= cnt_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      cur_ff       <= cur_in;
      out_image_ff <= out_image_in;
      out_row_ff   <= out_row_in;
      out_found_ff <= out_found_in;
      out_pos_ff   <= out_pos_in;
   end

endmodule : llzc_back

`default_nettype wire
